### hdl/printer_line_formatter_macros.svh
// ----------------------------------------------------------------------------
// Printer line formatter assertion macros
// Shorthand for clocked implication checks, reset disabled.
// ----------------------------------------------------------------------------
`ifndef PRINTER_LINE_FORMATTER_MACROS_SVH
`define PRINTER_LINE_FORMATTER_MACROS_SVH

// same-cycle implication on clk, disabled while arst_n is low
`define PLF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled while arst_n is low
`define PLF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/plf_pkg.sv
// ----------------------------------------------------------------------------
// Printer line formatter package
// Byte codes, register indexes and the remainder unit status type.
// ----------------------------------------------------------------------------
package plf_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_COLUMNS        = 3'd0,
		REG_TAB_WIDTH      = 3'd1,
		REG_LEFT_MARGIN    = 3'd2,
		REG_LINES_PER_PAGE = 3'd3,
		REG_BREAK_ON_FF    = 3'd4
	} plf_reg_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_WRAP  = 8'hB0;

	localparam logic [7:0] COLUMNS_MAX  = 8'd250;
	localparam logic [4:0] TAB_MAX      = 5'd16;
	localparam logic [5:0] MARGIN_MAX   = 6'd32;
	localparam logic [7:0] LPP_MIN      = 8'd5;

	// status of the column remainder unit
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [3:0] rem;
	} plf_rem_status_t;

	// control bytes printed as a space
	function automatic logic is_blanked(input logic [7:0] c);
		return (c == 8'd7) || (c == 8'd8) || (c == 8'd11) || (c == 8'd14) ||
		       (c == 8'd18) || (c == 8'd19) || (c == 8'd20) || (c == 8'd24) ||
		       (c == 8'd27) || (c == CH_DEL);
	endfunction

endpackage

### hdl/plf_rem.sv
// ----------------------------------------------------------------------------
// Column remainder unit
// Restoring remainder of an 8-bit column by a tab width, one bit a cycle.
// ----------------------------------------------------------------------------
module plf_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [7:0]               dividend,
	input  logic [4:0]               divisor,
	output plf_pkg::plf_rem_status_t status
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] step_q;
	logic [7:0] dividend_q;
	logic [4:0] divisor_q;
	logic [3:0] rem_q;
	logic [4:0] trial;
	logic [4:0] trial_sub;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial     = {rem_q, dividend_q[7]};
		trial_sub = (trial >= divisor_q) ? (trial - divisor_q) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[6:0], 1'b0};
			rem_q      <= trial_sub[3:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.rem  = rem_q;

endmodule

### hdl/printer_line_formatter.sv
// ----------------------------------------------------------------------------
// Printer line formatter
// Turns text bytes into the printer byte stream with margins, tabs and pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_byte, end_of_file) carries one text
//   item per handshake. Output channel (out_valid/out_ready, out_byte, last)
//   carries the printer bytes; last marks the final byte an item caused.
//   Items that cause no byte (a dropped tab or an ignored form feed, with no
//   margin due) complete silently.
//   An accepted item enters the item register, and its bytes are then
//   loaded from there into the output register.
//   Throughput: ordinary printable bytes on an open line flow at one item per
//   cycle while the output is not stalled. Margins, tab padding, wraps and
//   line/page ends are emitted one byte at a time; the item register holds
//   the item and in_ready stays low until its last byte is loaded.
//   A write to tab_width runs the column remainder unit, with in_ready low
//   while it runs, so that tab stops line up with the current column.
//   Reset: registers return to 80 columns, tab width 8, margin 0, 56 lines
//   per page, no form feed break; the line is closed at column 0.
//   Stall: a stalled output register holds its byte; the next byte waits and
//   input is refused once the item register is full.
// ----------------------------------------------------------------------------
`include "printer_line_formatter_macros.svh"

module printer_line_formatter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// configuration registers
	logic [7:0] columns_q;
	logic [4:0] tab_width_q;
	logic [5:0] left_margin_q;
	logic [7:0] lines_per_page_q;
	logic       break_on_ff_q;

	// line state
	logic [7:0] column_q;
	logic       line_open_q;
	logic [7:0] line_count_q;
	logic [3:0] tab_mod_q;     // column modulo effective tab width

	// item register and emit position
	logic       item_valid_s1;
	logic [7:0] item_byte_s1;
	logic       item_eof_s1;
	logic [5:0] idx_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	// remainder unit
	logic                     rem_start_q;
	plf_pkg::plf_rem_status_t rem_st;
	logic                     rem_active;

	// clamped configuration
	logic [7:0] cols_eff;
	logic [4:0] tab_eff;
	logic [5:0] margin_eff;
	logic [7:0] lpp_eff;

	// item plan
	logic [5:0] margin_cnt;
	logic [4:0] body_cnt;
	logic       body_is_char;
	logic [7:0] body_byte;
	logic       wrap;
	logic       lf;
	logic       ff;
	logic       end_page;
	logic [8:0] tab_target;
	logic [8:0] col_inc;
	logic [8:0] count_inc;
	logic [4:0] mod_inc;
	logic [7:0] nxt_column;
	logic       nxt_open;
	logic [7:0] nxt_count;
	logic [3:0] nxt_mod;

	// emit control
	logic [6:0] head_len;
	logic [6:0] total;
	logic [6:0] idx_ext;
	logic [6:0] tail_pos;
	logic [7:0] cur_byte;
	logic       cur_last;
	logic       slot_free;
	logic       emit;
	logic       item_done;
	logic       in_acc;

	always_comb begin
		cols_eff   = (columns_q == 8'd0) ? 8'd1 :
		             (columns_q > plf_pkg::COLUMNS_MAX) ? plf_pkg::COLUMNS_MAX : columns_q;
		tab_eff    = (tab_width_q > plf_pkg::TAB_MAX) ? plf_pkg::TAB_MAX : tab_width_q;
		margin_eff = (left_margin_q > plf_pkg::MARGIN_MAX) ? plf_pkg::MARGIN_MAX
		                                                   : left_margin_q;
		lpp_eff    = (lines_per_page_q < plf_pkg::LPP_MIN) ? plf_pkg::LPP_MIN
		                                                   : lines_per_page_q;
	end

	// Plan the whole item from the item register and the line state: margin
	// spaces, then the body (one byte or tab padding), then wrap mark, line
	// end and page end as needed. State moves when the item completes.
	always_comb begin
		tab_target = {1'b0, column_q} + {4'd0, tab_eff} - {5'd0, tab_mod_q};
		col_inc    = {1'b0, column_q} + 9'd1;
		count_inc  = {1'b0, line_count_q} + 9'd1;
		mod_inc    = {1'b0, tab_mod_q} + 5'd1;

		margin_cnt   = (!line_open_q && !item_eof_s1) ? margin_eff : 6'd0;
		body_cnt     = 5'd0;
		body_is_char = 1'b0;
		body_byte    = plf_pkg::CH_SPACE;
		wrap         = 1'b0;
		lf           = 1'b0;
		end_page     = 1'b0;
		nxt_column   = column_q;
		nxt_open     = 1'b1;
		nxt_mod      = tab_mod_q;

		if (item_eof_s1) begin
			lf = line_open_q;
		end else if (item_byte_s1 == plf_pkg::CH_FF) begin
			if (break_on_ff_q) begin
				lf       = 1'b1;
				end_page = 1'b1;
			end
		end else if (item_byte_s1 == plf_pkg::CH_TAB) begin
			if (tab_eff != 5'd0) begin
				if (tab_target >= {1'b0, cols_eff}) begin
					// pad to the limit only, none if already past it
					body_cnt = (cols_eff > column_q) ? 5'(cols_eff - column_q) : 5'd0;
					wrap     = 1'b1;
					lf       = 1'b1;
				end else begin
					body_cnt   = tab_eff - {1'b0, tab_mod_q};
					nxt_column = tab_target[7:0];
					nxt_mod    = 4'd0;
				end
			end
		end else if (item_byte_s1 == plf_pkg::CH_LF || item_byte_s1 == plf_pkg::CH_CR ||
		             item_byte_s1 == plf_pkg::CH_NUL) begin
			lf = 1'b1;
		end else begin
			body_cnt     = 5'd1;
			body_is_char = 1'b1;
			body_byte    = plf_pkg::is_blanked(item_byte_s1) ? plf_pkg::CH_SPACE
			                                                 : item_byte_s1;
			nxt_column   = col_inc[7:0];
			nxt_mod      = (tab_eff == 5'd0 || mod_inc == tab_eff) ? 4'd0 : mod_inc[3:0];
			if (col_inc >= {1'b0, cols_eff}) begin
				wrap = 1'b1;
				lf   = 1'b1;
			end
		end

		ff = item_eof_s1 || (lf && (end_page || count_inc >= {1'b0, lpp_eff}));

		nxt_count = line_count_q;
		if (lf) begin
			nxt_column = 8'd0;
			nxt_open   = 1'b0;
			nxt_mod    = 4'd0;
			nxt_count  = ff ? 8'd0 : count_inc[7:0];
		end
		if (item_eof_s1) begin
			nxt_column = 8'd0;
			nxt_open   = 1'b0;
			nxt_mod    = 4'd0;
			nxt_count  = 8'd0;
		end
	end

	// Pick the byte at the current emit position.
	always_comb begin
		head_len = {1'b0, margin_cnt} + {2'd0, body_cnt};
		total    = head_len + {6'd0, wrap} + {6'd0, lf} + {6'd0, ff};
		idx_ext  = {1'b0, idx_q};
		tail_pos = idx_ext - head_len;

		priority if (idx_ext < {1'b0, margin_cnt}) begin
			cur_byte = plf_pkg::CH_SPACE;
		end else if (idx_ext < head_len) begin
			cur_byte = body_is_char ? body_byte : plf_pkg::CH_SPACE;
		end else if (wrap && tail_pos == 7'd0) begin
			cur_byte = plf_pkg::CH_WRAP;
		end else if (lf && tail_pos == {6'd0, wrap}) begin
			cur_byte = plf_pkg::CH_LF;
		end else begin
			cur_byte = plf_pkg::CH_FF;
		end

		cur_last  = (idx_ext == total - 7'd1);
		slot_free = !out_valid_q || out_ready;
		emit      = item_valid_s1 && (total != 7'd0) && slot_free;
		item_done = item_valid_s1 && ((total == 7'd0) || (emit && cur_last));
	end

	assign rem_active = rem_start_q || rem_st.busy || rem_st.done;
	assign in_ready   = !rem_active && (!item_valid_s1 || item_done);
	assign in_acc     = in_valid && in_ready;

	// configuration writes; a tab width change starts a remainder pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q        <= 8'd80;
			tab_width_q      <= 5'd8;
			left_margin_q    <= 6'd0;
			lines_per_page_q <= 8'd56;
			break_on_ff_q    <= 1'b0;
			rem_start_q      <= 1'b0;
		end else begin
			rem_start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					plf_pkg::REG_COLUMNS:        columns_q        <= cfg_data;
					plf_pkg::REG_TAB_WIDTH: begin
						tab_width_q <= cfg_data[4:0];
						rem_start_q <= 1'b1;
					end
					plf_pkg::REG_LEFT_MARGIN:    left_margin_q    <= cfg_data[5:0];
					plf_pkg::REG_LINES_PER_PAGE: lines_per_page_q <= cfg_data;
					plf_pkg::REG_BREAK_ON_FF:    break_on_ff_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// Recompute the column phase against the new tab width.
	plf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start_q),
		.dividend (column_q),
		.divisor  (tab_eff),
		.status   (rem_st)
	);

	// line state, item register, emit position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= 8'd0;
			line_open_q   <= 1'b0;
			line_count_q  <= 8'd0;
			tab_mod_q     <= 4'd0;
			item_valid_s1 <= 1'b0;
			idx_q         <= 6'd0;
			out_valid_q   <= 1'b0;
		end else begin
			// a finished remainder pass sets the phase, else a finished item
			if (rem_st.done) begin
				tab_mod_q <= (tab_eff == 5'd0) ? 4'd0 : rem_st.rem;
			end else if (item_done) begin
				tab_mod_q <= nxt_mod;
			end
			if (item_done) begin
				column_q     <= nxt_column;
				line_open_q  <= nxt_open;
				line_count_q <= nxt_count;
				idx_q        <= 6'd0;
			end else if (emit) begin
				idx_q <= idx_q + 6'd1;
			end
			// load the next item, or drop the finished one
			if (in_acc) begin
				item_valid_s1 <= 1'b1;
			end else if (item_done) begin
				item_valid_s1 <= 1'b0;
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_byte_s1 <= in_byte;
			item_eof_s1  <= end_of_file;
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			last_q     <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	`PLF_ASSERT_IMP(a_no_accept_during_rem, rem_active, !in_ready,
		"item accepted while the column remainder is being computed")
	`PLF_ASSERT_IMP(a_closed_line_at_col0, !line_open_q, column_q == 8'd0,
		"closed line with nonzero column")
	`PLF_ASSERT_IMP(a_tab_phase_in_range, (tab_eff != 5'd0) && !rem_active,
		{1'b0, tab_mod_q} < tab_eff, "tab phase not below tab width")
	`PLF_ASSERT_NXT(a_eof_clears_state, item_done && item_eof_s1,
		(column_q == 8'd0) && !line_open_q && (line_count_q == 8'd0),
		"end of file did not clear the line state")
	`PLF_ASSERT_IMP(a_done_with_bytes_emits, item_done && (total != 7'd0), emit && cur_last,
		"item completed without emitting its last byte")

endmodule
